// ===== src/nitr_pkg.sv =====
// Shared types and constants for the nested interval timestamp recorder.
`timescale 1ns / 1ps
`default_nettype none
package nitr_pkg;

  localparam int unsigned TableDepth = 16;
  localparam int unsigned IdxW       = $clog2(TableDepth);
  localparam int unsigned CntW       = $clog2(TableDepth + 1);
  localparam int unsigned TimeW      = 32;
  localparam int unsigned LabelW     = 16;
  localparam int unsigned LevelW     = 4;
  localparam int unsigned StatusW    = 3;

  typedef enum logic [1:0] {
    CMD_BEGIN = 2'd0,
    CMD_END   = 2'd1,
    CMD_READ  = 2'd2,
    CMD_TOTAL = 2'd3
  } nitr_cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK          = 3'd0,
    ST_FULL        = 3'd1,
    ST_NONE_ACTIVE = 3'd2,
    ST_BAD_INDEX   = 3'd3,
    ST_RUNNING     = 3'd4,
    ST_EMPTY       = 3'd5
  } nitr_status_e;

  typedef struct packed {
    nitr_cmd_e          cmd;
    logic [TimeW-1:0]   time_us;
    logic [LabelW-1:0]  label;
    logic [IdxW-1:0]    idx;
  } nitr_req_t;

  typedef struct packed {
    nitr_status_e       status;
    logic [LevelW-1:0]  level;
    logic [LabelW-1:0]  label;
    logic               finished;
    logic [TimeW-1:0]   duration;
  } nitr_result_t;

endpackage
`default_nettype wire

// ===== src/nitr_exec.sv =====
// Entry table, open-interval stack and per-command result logic.
`timescale 1ns / 1ps
`default_nettype none
module nitr_exec (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  fire_i,
  input  wire nitr_pkg::nitr_req_t   req_i,
  output nitr_pkg::nitr_result_t     res_o
);

  logic [nitr_pkg::TimeW-1:0]  start_times_q [nitr_pkg::TableDepth];
  logic [nitr_pkg::TimeW-1:0]  end_times_q   [nitr_pkg::TableDepth];
  logic [nitr_pkg::LevelW-1:0] levels_q      [nitr_pkg::TableDepth];
  logic [nitr_pkg::LabelW-1:0] labels_q      [nitr_pkg::TableDepth];
  logic [nitr_pkg::IdxW-1:0]   stack_q       [nitr_pkg::TableDepth];
  logic [nitr_pkg::TableDepth-1:0] done_q, done_d;

  logic [nitr_pkg::CntW-1:0]  used_q, used_d;
  logic [nitr_pkg::CntW-1:0]  depth_q, depth_d;
  logic [nitr_pkg::TimeW-1:0] first_start_q, first_start_d;
  logic [nitr_pkg::TimeW-1:0] last_end_q, last_end_d;

  logic [nitr_pkg::IdxW-1:0]  new_idx;
  logic [nitr_pkg::IdxW-1:0]  push_ptr;
  logic [nitr_pkg::IdxW-1:0]  pop_ptr;
  logic [nitr_pkg::IdxW-1:0]  pop_idx;
  logic [nitr_pkg::CntW-1:0]  depth_dec;
  logic [nitr_pkg::CntW-1:0]  used_dec;
  logic                       do_begin;
  logic                       do_end;
  nitr_pkg::nitr_result_t     res;

  assign new_idx   = used_q[nitr_pkg::IdxW-1:0];
  assign push_ptr  = depth_q[nitr_pkg::IdxW-1:0];
  assign depth_dec = depth_q - nitr_pkg::CntW'(1);
  assign used_dec  = used_q - nitr_pkg::CntW'(1);
  assign pop_ptr   = depth_dec[nitr_pkg::IdxW-1:0];
  assign pop_idx   = stack_q[pop_ptr];

  always_comb begin
    res           = '0;
    res.status    = nitr_pkg::ST_OK;
    do_begin      = 1'b0;
    do_end        = 1'b0;
    used_d        = used_q;
    depth_d       = depth_q;
    done_d        = done_q;
    first_start_d = first_start_q;
    last_end_d    = last_end_q;
    case (req_i.cmd)
      nitr_pkg::CMD_BEGIN: begin
        if (used_q >= nitr_pkg::CntW'(nitr_pkg::TableDepth) ||
            depth_q >= nitr_pkg::CntW'(nitr_pkg::TableDepth)) begin
          res.status = nitr_pkg::ST_FULL;
        end else begin
          do_begin        = fire_i;
          used_d          = used_q + nitr_pkg::CntW'(1);
          depth_d         = depth_q + nitr_pkg::CntW'(1);
          done_d[new_idx] = 1'b0;
          if (used_q == '0) begin
            first_start_d = req_i.time_us;
          end
        end
      end
      nitr_pkg::CMD_END: begin
        if (depth_q == '0) begin
          res.status = nitr_pkg::ST_NONE_ACTIVE;
        end else begin
          do_end          = fire_i;
          depth_d         = depth_dec;
          done_d[pop_idx] = 1'b1;
          // last entry's end is the one the total span needs
          if (pop_idx == used_dec[nitr_pkg::IdxW-1:0]) begin
            last_end_d = req_i.time_us;
          end
        end
      end
      nitr_pkg::CMD_READ: begin
        if ({1'b0, req_i.idx} >= used_q) begin
          res.status = nitr_pkg::ST_BAD_INDEX;
        end else begin
          res.level    = levels_q[req_i.idx];
          res.label    = labels_q[req_i.idx];
          res.finished = done_q[req_i.idx];
          if (done_q[req_i.idx]) begin
            res.duration = end_times_q[req_i.idx] - start_times_q[req_i.idx];
          end
        end
      end
      nitr_pkg::CMD_TOTAL: begin
        if (used_q == '0) begin
          res.status = nitr_pkg::ST_EMPTY;
        end else if (depth_q != '0) begin
          res.status = nitr_pkg::ST_RUNNING;
        end else begin
          res.duration = last_end_q - first_start_q;
        end
      end
      default: begin
        res.status = nitr_pkg::ST_OK;
      end
    endcase
  end

  assign res_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q  <= '0;
      depth_q <= '0;
      done_q  <= '0;
    end else if (fire_i) begin
      used_q  <= used_d;
      depth_q <= depth_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      first_start_q <= first_start_d;
      last_end_q    <= last_end_d;
    end
    if (do_begin) begin
      start_times_q[new_idx] <= req_i.time_us;
      labels_q[new_idx]      <= req_i.label;
      levels_q[new_idx]      <= depth_q[nitr_pkg::LevelW-1:0];
      stack_q[push_ptr]      <= new_idx;
    end
    if (do_end) begin
      end_times_q[pop_idx] <= req_i.time_us;
    end
  end

endmodule
`default_nettype wire

// ===== src/nested_interval_timestamp_recorder_top.sv =====
// Top level of the nested interval timestamp recorder.
//
//   channel | valid      | stall      | payload
//   --------+------------+------------+----------------------------------------------
//   in      | in_valid_i | in_stall_o | command_i, time_us_i, label_tag_i,
//           |            |            | entry_index_i
//   out     | out_valid_o| out_stall_i| status_o, nesting_level_o, entry_label_o,
//           |            |            | entry_finished_o, duration_us_o
//
// One item per cycle while the output is not stalled; the input register captures an item and
// the table lookup/update then loads its result register from it.
// The 16-entry table lives in flip-flops, read and written in the same cycle.
// Reset clears the fill count, the open depth and the ended flags; table
// contents are left as they are. An output stall holds the result register
// and, once the input register is occupied, backs up into in_stall_o.
`timescale 1ns / 1ps
`default_nettype none
module nested_interval_timestamp_recorder_top (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output      logic                           in_stall_o,
  input  wire logic [1:0]                     command_i,
  input  wire logic [nitr_pkg::TimeW-1:0]     time_us_i,
  input  wire logic [nitr_pkg::LabelW-1:0]    label_tag_i,
  input  wire logic [nitr_pkg::IdxW-1:0]      entry_index_i,
  output      logic                           out_valid_o,
  input  wire logic                           out_stall_i,
  output      logic [nitr_pkg::StatusW-1:0]   status_o,
  output      logic [nitr_pkg::LevelW-1:0]    nesting_level_o,
  output      logic [nitr_pkg::LabelW-1:0]    entry_label_o,
  output      logic                           entry_finished_o,
  output      logic [nitr_pkg::TimeW-1:0]     duration_us_o
);

  logic                   in_valid_q;
  nitr_pkg::nitr_req_t    req_q;
  logic                   out_valid_q;
  nitr_pkg::nitr_result_t res_q;
  nitr_pkg::nitr_result_t res;
  logic                   advance;
  logic                   fire;

  // the working stage moves whenever the result register is free or drained
  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      req_q.cmd     <= nitr_pkg::nitr_cmd_e'(command_i);
      req_q.time_us <= time_us_i;
      req_q.label   <= label_tag_i;
      req_q.idx     <= entry_index_i;
    end
    if (fire) begin
      res_q <= res;
    end
  end

  nitr_exec u_exec (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .req_i  (req_q),
    .res_o  (res)
  );

  assign out_valid_o      = out_valid_q;
  assign status_o         = res_q.status;
  assign nesting_level_o  = res_q.level;
  assign entry_label_o    = res_q.label;
  assign entry_finished_o = res_q.finished;
  assign duration_us_o    = res_q.duration;

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking testbench for the nested interval timestamp recorder.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;

  localparam int unsigned HangLimit = 2000;  // cycles with no item moving on either side
  localparam int unsigned DrainWait = 8;     // input register and result register plus margin

  // Shadow copy of the interval table plus the results still owed by the block.
  class interval_table_check;
    logic [nitr_pkg::TimeW-1:0]  start_us [nitr_pkg::TableDepth];
    logic [nitr_pkg::TimeW-1:0]  end_us   [nitr_pkg::TableDepth];
    logic [nitr_pkg::LevelW-1:0] levels   [nitr_pkg::TableDepth];
    logic [nitr_pkg::LabelW-1:0] tags     [nitr_pkg::TableDepth];
    logic                        ended    [nitr_pkg::TableDepth];
    int unsigned                 open_stack [nitr_pkg::TableDepth];
    int unsigned                 used;
    int unsigned                 depth;
    nitr_pkg::nitr_result_t      expected_results [$];
    int unsigned                 mismatches;

    function new();
      used = 0;
      depth = 0;
      mismatches = 0;
      foreach (ended[i]) ended[i] = 1'b0;
    endfunction

    task report(string what, logic [nitr_pkg::TimeW-1:0] got,
                logic [nitr_pkg::TimeW-1:0] want);
      $display("%0t: mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
      mismatches++;
    endtask

    // Work out the result of one accepted command and queue it.
    function void predict_command(nitr_pkg::nitr_cmd_e cmd, logic [nitr_pkg::TimeW-1:0] now,
                                  logic [nitr_pkg::LabelW-1:0] tag,
                                  logic [nitr_pkg::IdxW-1:0] idx);
      nitr_pkg::nitr_result_t r;
      int unsigned            e;
      r = '0;
      r.status = nitr_pkg::ST_OK;
      case (cmd)
        nitr_pkg::CMD_BEGIN: begin
          if (used >= nitr_pkg::TableDepth || depth >= nitr_pkg::TableDepth) begin
            r.status = nitr_pkg::ST_FULL;
          end else begin
            start_us[used] = now;
            tags[used]     = tag;
            levels[used]   = (depth > 15) ? 4'd15 : depth[nitr_pkg::LevelW-1:0];
            ended[used]    = 1'b0;
            open_stack[depth] = used;
            depth++;
            used++;
          end
        end
        nitr_pkg::CMD_END: begin
          if (depth == 0) begin
            r.status = nitr_pkg::ST_NONE_ACTIVE;
          end else begin
            depth--;
            e = open_stack[depth];
            end_us[e] = now;
            ended[e]  = 1'b1;
          end
        end
        nitr_pkg::CMD_READ: begin
          if (idx >= used) begin
            r.status = nitr_pkg::ST_BAD_INDEX;
          end else begin
            r.level    = levels[idx];
            r.label    = tags[idx];
            r.finished = ended[idx];
            if (ended[idx]) r.duration = end_us[idx] - start_us[idx];
          end
        end
        default: begin
          // empty table wins over open timers
          if (used == 0) r.status = nitr_pkg::ST_EMPTY;
          else if (depth != 0) r.status = nitr_pkg::ST_RUNNING;
          else r.duration = end_us[used-1] - start_us[0];
        end
      endcase
      expected_results.push_back(r);
    endfunction

    task check_result(logic [nitr_pkg::StatusW-1:0] status,
                      logic [nitr_pkg::LevelW-1:0] level,
                      logic [nitr_pkg::LabelW-1:0] label, logic finished,
                      logic [nitr_pkg::TimeW-1:0] duration);
      nitr_pkg::nitr_result_t want;
      if (expected_results.size() == 0) begin
        report("result with nothing pending", {29'd0, status}, '0);
        return;
      end
      want = expected_results.pop_front();
      if (status !== want.status)     report("status", {29'd0, status}, {29'd0, want.status});
      if (level !== want.level)       report("nesting level", {28'd0, level}, {28'd0, want.level});
      if (label !== want.label)       report("entry label", {16'd0, label}, {16'd0, want.label});
      if (finished !== want.finished) report("finished flag", {31'd0, finished},
                                             {31'd0, want.finished});
      if (duration !== want.duration) report("duration", duration, want.duration);
    endtask
  endclass

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          in_valid_i = 1'b0;
  logic                          in_stall_o;
  logic [1:0]                    command_i = '0;
  logic [nitr_pkg::TimeW-1:0]    time_us_i = '0;
  logic [nitr_pkg::LabelW-1:0]   label_tag_i = '0;
  logic [nitr_pkg::IdxW-1:0]     entry_index_i = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic [nitr_pkg::StatusW-1:0]  status_o;
  logic [nitr_pkg::LevelW-1:0]   nesting_level_o;
  logic [nitr_pkg::LabelW-1:0]   entry_label_o;
  logic                          entry_finished_o;
  logic [nitr_pkg::TimeW-1:0]    duration_us_o;

  int unsigned         idle_pct = 0;    // sender: chance of an empty cycle
  int unsigned         stall_pct = 0;   // receiver: chance of a stall cycle
  int unsigned         quiet_cycles = 0;
  interval_table_check table_chk = new();

  nested_interval_timestamp_recorder_top i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .command_i        (command_i),
    .time_us_i        (time_us_i),
    .label_tag_i      (label_tag_i),
    .entry_index_i    (entry_index_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .nesting_level_o  (nesting_level_o),
    .entry_label_o    (entry_label_o),
    .entry_finished_o (entry_finished_o),
    .duration_us_o    (duration_us_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Output stall changes only on the falling edge.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Both handshakes are sampled on the rising edge; the hang counter lives here too.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        table_chk.predict_command(nitr_pkg::nitr_cmd_e'(command_i), time_us_i, label_tag_i,
                                  entry_index_i);
      end
      if (out_valid_o && !out_stall_i) begin
        table_chk.check_result(status_o, nesting_level_o, entry_label_o,
                               entry_finished_o, duration_us_o);
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= HangLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Present one command and hold it until the block takes it.
  task automatic send_command(nitr_pkg::nitr_cmd_e cmd, logic [nitr_pkg::TimeW-1:0] now,
                              logic [nitr_pkg::LabelW-1:0] tag,
                              logic [nitr_pkg::IdxW-1:0] idx);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
    end
    @(negedge clk_i);
    in_valid_i    = 1'b1;
    command_i     = cmd;
    time_us_i     = now;
    label_tag_i   = tag;
    entry_index_i = idx;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Random mix: ends close the nest a few at a time, reads and totals dominate.
  task automatic random_phase(int unsigned count, int unsigned sender_idle,
                              int unsigned recv_stall);
    nitr_pkg::nitr_cmd_e cmd;
    int unsigned         pick;
    idle_pct  = sender_idle;
    stall_pct = recv_stall;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 5)       cmd = nitr_pkg::CMD_BEGIN;
      else if (pick < 12) cmd = nitr_pkg::CMD_END;
      else if (pick < 70) cmd = nitr_pkg::CMD_READ;
      else                cmd = nitr_pkg::CMD_TOTAL;
      send_command(cmd, $urandom, nitr_pkg::LabelW'($urandom_range(16'hFFFF)),
                   nitr_pkg::IdxW'($urandom_range(nitr_pkg::TableDepth - 1)));
    end
  endtask

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: errors on an empty table, then one nest that fills all 16 entries.
    send_command(nitr_pkg::CMD_TOTAL, '0, '0, '0);
    send_command(nitr_pkg::CMD_END, 32'hFFFF_FFFF, 16'hFFFF, 4'hF);
    send_command(nitr_pkg::CMD_READ, '0, '0, 4'd0);
    send_command(nitr_pkg::CMD_BEGIN, 32'hFFFF_FFF0, 16'hFFFF, '0);
    send_command(nitr_pkg::CMD_READ, '0, '0, 4'hF);
    send_command(nitr_pkg::CMD_READ, '0, '0, 4'd0);
    send_command(nitr_pkg::CMD_BEGIN, '0, '0, '0);
    repeat (nitr_pkg::TableDepth - 2) begin
      send_command(nitr_pkg::CMD_BEGIN, $urandom, nitr_pkg::LabelW'($urandom_range(16'hFFFF)),
                   nitr_pkg::IdxW'($urandom_range(15)));
    end
    send_command(nitr_pkg::CMD_READ, '0, '0, 4'hF);   // deepest entry, level 15, still open
    send_command(nitr_pkg::CMD_TOTAL, '0, '0, '0);    // timers running
    send_command(nitr_pkg::CMD_BEGIN, '1, '1, '1);    // table full

    random_phase(90, 0, 0);
    random_phase(90, 69, 0);
    random_phase(90, 0, 69);
    random_phase(90, 33, 33);
    random_phase(90, 0, 0);

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (table_chk.expected_results.size() != 0) @(posedge clk_i);
    stall_pct = 0;
    repeat (DrainWait) @(posedge clk_i);

    if (table_chk.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
src/nitr_pkg.sv
src/nitr_exec.sv
src/nested_interval_timestamp_recorder_top.sv
bench/tb_top.sv
